[design/todcd_pkg.sv]
`default_nettype none

package todcd_pkg;

  // Configuration register map (word index)
  localparam logic RegIdxTps = 1'b0;
  localparam logic [15:0] TpsReset = 16'd125;

  // Time-of-day reset values and rollover limits
  localparam logic [5:0] SecReset = 6'd30;
  localparam logic [5:0] MinReset = 6'd23;
  localparam logic [4:0] HourReset = 5'd10;
  localparam logic [5:0] SecPerMin = 6'd60;
  localparam logic [5:0] MinPerHour = 6'd60;
  localparam logic [4:0] HourPerDay = 5'd24;

  // Characters
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharG = 8'h47;
  localparam logic [7:0] CharR = 8'h72;
  localparam logic [7:0] CharE = 8'h65;
  localparam logic [7:0] CharS = 8'h73;
  localparam logic [7:0] CharI = 8'h69;
  localparam logic [7:0] CharT = 8'h74;

  // Position of the final character in a run
  localparam logic [3:0] LastTimeIdx = 4'd7;
  localparam logic [3:0] LastErrIdx = 4'd13;

  // Default depth of the pending-run queue
  localparam int unsigned RunDepthDef = 2;

  // One pending display run: the time after the rollover and the error mark
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       err;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } run_push_t;

  // Tens digit of a value below 64
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  // Units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] prod;
    prod = 6'({3'b0, tens_of(v)} * 6'd10);
    return 4'(v - prod);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return 8'(CharZero + {4'b0, d});
  endfunction

  // Character at position idx of a run
  function automatic logic [7:0] char_at(input run_t r, input logic [3:0] idx);
    logic [7:0] c;
    logic [5:0] h;
    h = {1'b0, r.hours};
    case (idx)
      4'd0: c = (r.hours > 5'd9) ? digit_char({1'b0, tens_of(h)}) : CharComma;
      4'd1: c = digit_char(units_of(h));
      4'd2: c = CharColon;
      4'd3: c = digit_char({1'b0, tens_of(r.minutes)});
      4'd4: c = digit_char(units_of(r.minutes));
      4'd5: c = CharColon;
      4'd6: c = digit_char({1'b0, tens_of(r.seconds)});
      4'd7: c = digit_char(units_of(r.seconds));
      4'd8: c = CharG;
      4'd9: c = CharR;
      4'd10: c = CharE;
      4'd11: c = CharS;
      4'd12: c = CharI;
      4'd13: c = CharT;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/todcd_if.sv]
`default_nettype none

// Input item channel: timer events
interface todcd_in_if;
  logic valid;
  logic ready;
  logic match_event;
  logic overflow_flag;

  modport source (output valid, output match_event, output overflow_flag, input ready);
  modport sink (input valid, input match_event, input overflow_flag, output ready);
endinterface

// Result item channel: display characters
interface todcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] display_char;
  logic       cursor_home;
  logic       error_halt;
  logic       last_of_run;

  modport source (output valid, output display_char, output cursor_home,
                  output error_halt, output last_of_run, input ready);
  modport sink (input valid, input display_char, input cursor_home,
                input error_halt, input last_of_run, output ready);
endinterface

`default_nettype wire

[design/todcd_serializer.sv]
`default_nettype none

module todcd_serializer
  import todcd_pkg::*;
#(
  parameter int unsigned RunDepth = RunDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire run_push_t push_i,
  output logic           full_o,
  todcd_out_if.source    out_if
);

  localparam int unsigned PtrW = $clog2(RunDepth);
  localparam int unsigned CntW = $clog2(RunDepth + 1);

  run_t            mem_q [RunDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]      idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      char_q;
  logic            home_q, err_q, last_q;

  run_t head;
  logic last_char, load, pop;

  // Head run and the character position within it
  assign head      = mem_q[rd_ptr_q];
  assign last_char = head.err ? (idx_q == LastErrIdx) : (idx_q == LastTimeIdx);
  assign load      = (cnt_q != '0) && (!out_valid_q || out_if.ready);
  assign pop       = load && last_char;
  assign full_o    = (cnt_q == CntW'(RunDepth));

  // Run storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.run;
    end
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(RunDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(RunDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i.valid) - CntW'(pop);
  end

  // Character index and output valid
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last_char ? 4'd0 : idx_q + 4'd1;
    end
    out_valid_d = load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_at(head, idx_q);
      home_q <= (idx_q == 4'd0);
      err_q  <= (idx_q > LastTimeIdx);
      last_q <= last_char;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.display_char = char_q;
  assign out_if.cursor_home  = home_q;
  assign out_if.error_halt   = err_q;
  assign out_if.last_of_run  = last_q;

endmodule

`default_nettype wire

[design/time_of_day_clock_display.sv]
// A run is first written into the pending-run queue, then its first character is loaded into the output register.
// Throughput: one item per cycle; a second rollover yields 8 characters (14 with the error text),
// one per cycle unless the output stalls; input stalls only while the pending-run queue is full.
// The queue (RunDepth runs) and the character serializer set the sustained rate.
// Reset (async, active low): time 10:23:30, tick count 0, ticks_per_second 125, not halted.
`default_nettype none

module time_of_day_clock_display
  import todcd_pkg::*;
#(
  parameter int unsigned RunDepth = RunDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  todcd_in_if.sink         in_if,
  todcd_out_if.source      out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] tps_q;
  logic [15:0] tick_q, tick_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic        halted_q, halted_d;

  logic        ser_full;
  logic        accept, count, roll;
  logic [16:0] tick_next;
  run_push_t   push;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxTps) ? {16'b0, tps_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegIdxTps)) begin
      tps_q <= pwdata[15:0];
    end
  end

  // Input handshake
  assign in_if.ready = !ser_full;
  assign accept      = in_if.valid && in_if.ready;
  assign count       = accept && in_if.match_event && !halted_q;

  // Prescaler and time-of-day update
  assign tick_next = {1'b0, tick_q} + 17'd1;
  assign roll      = (tick_next >= {1'b0, tps_q});

  always_comb begin
    tick_d   = tick_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    halted_d = halted_q;
    if (count) begin
      if (!roll) begin
        tick_d = tick_next[15:0];
      end else begin
        tick_d   = '0;
        halted_d = in_if.overflow_flag;
        if (sec_q + 6'd1 >= SecPerMin) begin
          sec_d = '0;
          if (min_q + 6'd1 >= MinPerHour) begin
            min_d  = '0;
            hour_d = (hour_q + 5'd1 >= HourPerDay) ? 5'd0 : hour_q + 5'd1;
          end else begin
            min_d = min_q + 6'd1;
          end
        end else begin
          sec_d = sec_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      sec_q    <= SecReset;
      min_q    <= MinReset;
      hour_q   <= HourReset;
      halted_q <= 1'b0;
    end else begin
      tick_q   <= tick_d;
      sec_q    <= sec_d;
      min_q    <= min_d;
      hour_q   <= hour_d;
      halted_q <= halted_d;
    end
  end

  // Hand the new time to the character serializer
  always_comb begin
    push.valid       = count && roll;
    push.run.hours   = hour_d;
    push.run.minutes = min_d;
    push.run.seconds = sec_d;
    push.run.err     = in_if.overflow_flag;
  end

  todcd_serializer #(
    .RunDepth (RunDepth)
  ) u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (ser_full),
    .out_if (out_if)
  );

`ifndef SYNTH
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !ser_full)
    else $error("run pushed into a full queue");

  a_err_char_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.error_halt) |-> halted_q)
    else $error("error text emitted while not halted");

  a_home_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.cursor_home) |-> (!out_if.error_halt && !out_if.last_of_run))
    else $error("cursor home on a non-leading character");
`endif

endmodule

`default_nettype wire
